### design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// shared types and constants of the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfha_pkg;

   localparam int SEG_COUNT = 64;
   localparam int IDX_W     = $clog2(SEG_COUNT);
   localparam int CNT_W     = $clog2(SEG_COUNT + 1);

   localparam logic [31:0] HDR_BYTES   = 32'd16;
   localparam logic [31:0] ZONE_BYTES  = 32'd4;
   localparam logic [31:0] ROUND_LIMIT = 32'hFFFF_FFFC;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_BADFREE = 2'd2,
      ST_NOSPLIT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_SEARCH, S_CALC1, S_CALC2, S_APPLY, S_APPLY2, S_FIN
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        used;
   } entry_type;

   // search key broadcast to every cell
   typedef struct packed {
      logic        is_alloc;
      logic [31:0] size;
      logic [31:0] hdr;
   } key_type;

   // search token passed down the chain
   typedef struct packed {
      logic             found;
      logic             just;
      logic [IDX_W-1:0] idx;
      logic [31:0]      start;
      logic [31:0]      size;
      logic             used;
      logic             pv;
      logic             pu;
      logic [31:0]      ps;
      logic             nv;
      logic             nu;
      logic [31:0]      ns;
      logic             lv;
      logic             lu;
      logic [31:0]      ls;
   } tok_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             start_en;
      logic [31:0]      start;
      logic             size_en;
      logic [31:0]      size;
      logic             used_en;
      logic             used;
   } wr_type;

   // table update broadcast to every cell
   typedef struct packed {
      logic             shr;
      logic             shl;
      logic [IDX_W-1:0] sh_idx;
      wr_type           wa;
      wr_type           wb;
   } cmd_type;

endpackage

### design/bfha_cell.sv
// ----------------------------------------------------------------------------
// bfha_cell
// one segment entry with its search stage and shift neighbours
// ----------------------------------------------------------------------------
module bfha_cell (
   input  logic                        clock,
   input  logic [bfha_pkg::IDX_W-1:0]  pos,
   input  logic [bfha_pkg::CNT_W-1:0]  count,
   input  bfha_pkg::key_type           key,
   input  bfha_pkg::cmd_type           cmd,
   input  bfha_pkg::entry_type         left_entry,
   input  bfha_pkg::entry_type         right_entry,
   output bfha_pkg::entry_type         entry_out,
   input  bfha_pkg::tok_type           tok_from_prev,
   output bfha_pkg::tok_type           tok_to_next
);

   bfha_pkg::entry_type entry_ff, entry_in;
   bfha_pkg::tok_type   tok_ff, tok_in;
   logic                valid, cand;

   assign valid = bfha_pkg::CNT_W'(pos) < count;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shr && pos > cmd.sh_idx) begin
         entry_in = left_entry;
      end
      if (cmd.shl && pos >= cmd.sh_idx) begin
         entry_in = right_entry;
      end
      if (cmd.wa.en && pos == cmd.wa.idx) begin
         if (cmd.wa.start_en) entry_in.start = cmd.wa.start;
         if (cmd.wa.size_en)  entry_in.size  = cmd.wa.size;
         if (cmd.wa.used_en)  entry_in.used  = cmd.wa.used;
      end
      if (cmd.wb.en && pos == cmd.wb.idx) begin
         if (cmd.wb.start_en) entry_in.start = cmd.wb.start;
         if (cmd.wb.size_en)  entry_in.size  = cmd.wb.size;
         if (cmd.wb.used_en)  entry_in.used  = cmd.wb.used;
      end
   end

   always_comb begin
      if (key.is_alloc) begin
         cand = valid && !entry_ff.used && entry_ff.size >= key.size &&
                (!tok_from_prev.found || entry_ff.size < tok_from_prev.size);
      end else begin
         cand = valid && !tok_from_prev.found && entry_ff.start == key.hdr;
      end
      tok_in = tok_from_prev;
      if (cand) begin
         tok_in.found = 1'b1;
         tok_in.just  = 1'b1;
         tok_in.idx   = pos;
         tok_in.start = entry_ff.start;
         tok_in.size  = entry_ff.size;
         tok_in.used  = entry_ff.used;
         tok_in.pv    = tok_from_prev.lv;
         tok_in.pu    = tok_from_prev.lu;
         tok_in.ps    = tok_from_prev.ls;
         tok_in.nv    = 1'b0;
      end else if (tok_from_prev.just) begin
         tok_in.just = 1'b0;
         tok_in.nv   = valid;
         tok_in.nu   = entry_ff.used;
         tok_in.ns   = entry_ff.size;
      end
      tok_in.lv = valid;
      tok_in.lu = entry_ff.used;
      tok_in.ls = entry_ff.size;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tok_ff   <= tok_in;
   end

   assign entry_out   = entry_ff;
   assign tok_to_next = tok_ff;

endmodule

### design/bfha_chain.sv
// ----------------------------------------------------------------------------
// bfha_chain
// row of segment cells, shift links and search token path
// ----------------------------------------------------------------------------
module bfha_chain (
   input  logic                        clock,
   input  logic [bfha_pkg::CNT_W-1:0]  count,
   input  bfha_pkg::key_type           key,
   input  bfha_pkg::cmd_type           cmd,
   output bfha_pkg::tok_type           tail_tok
);

   bfha_pkg::entry_type entries [bfha_pkg::SEG_COUNT];
   bfha_pkg::tok_type   toks    [bfha_pkg::SEG_COUNT+1];

   // empty token enters the head every cycle
   assign toks[0] = '0;

   for (genvar k = 0; k < bfha_pkg::SEG_COUNT; k++) begin : g_cell
      bfha_pkg::entry_type lft, rgt;
      if (k == 0) begin : g_l0
         assign lft = entries[k];
      end else begin : g_l
         assign lft = entries[k-1];
      end
      if (k == bfha_pkg::SEG_COUNT - 1) begin : g_rn
         assign rgt = entries[k];
      end else begin : g_r
         assign rgt = entries[k+1];
      end
      bfha_cell u_cell (
         .clock         (clock),
         .pos           (bfha_pkg::IDX_W'(k)),
         .count         (count),
         .key           (key),
         .cmd           (cmd),
         .left_entry    (lft),
         .right_entry   (rgt),
         .entry_out     (entries[k]),
         .tok_from_prev (toks[k]),
         .tok_to_next   (toks[k+1])
      );
   end

   assign tail_tok = toks[bfha_pkg::SEG_COUNT];

endmodule

### design/best_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// best-fit segment allocator with coalescing over a chain of table cells
// ----------------------------------------------------------------------------
// sequence after acceptance: init via S_INIT, nop and null free straight to S_FIN,
//   allocate and free SEARCH, CALC1, CALC2, APPLY (and APPLY2 for a free merging both
//   neighbours), FIN; a miss ends after CALC1; the search token walks one cell a cycle
// throughput: one transaction at a time, the next taken while a result waits
// reset: synchronous, active high; clears control state and the segment count
//   (no arena); table contents stay undefined until written
module best_fit_heap_allocator_top (
   input  logic        clock,
   input  logic        reset,
   // request channel, tdata: opcode[1:0], request_size[33:2],
   // payload_address[65:34], zero fill up to 72 bits
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // response channel, tdata: result_address[31:0], status[33:32], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // configuration writes: index 0 arena_base, index 1 arena_bytes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int N = bfha_pkg::SEG_COUNT;
   localparam int IW = bfha_pkg::IDX_W;
   localparam int CW = bfha_pkg::CNT_W;

   bfha_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [31:0] base_ff, bytes_ff;

   // transaction registers
   bfha_pkg::opcode_type op_ff;
   logic [31:0] size_ff, hdr_ff;
   logic [IW-1:0] cnt_ff;
   logic [CW-1:0] count_ff;
   bfha_pkg::tok_type tok_ff, tail_tok;
   logic [31:0] rest_ff, addr_ff, a_ff, b_ff, m_ff, piece_ff, nsum_ff, restm_ff;
   logic split_ff;
   bfha_pkg::status_type status_ff;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff;
   bfha_pkg::status_type rsp_status_ff;

   bfha_pkg::key_type key;
   bfha_pkg::cmd_type cmd;

   // request fields
   bfha_pkg::opcode_type req_op;
   logic [31:0] req_size, req_ptr, req_rounded;
   logic        accept;

   assign req_op   = bfha_pkg::opcode_type'(req_tdata[1:0]);
   assign req_size = req_tdata[33:2];
   assign req_ptr  = req_tdata[65:34];
   assign accept   = req_tvalid && req_tready;

   // round up to four, saturate where that would wrap
   assign req_rounded = (req_size > bfha_pkg::ROUND_LIMIT) ? bfha_pkg::ROUND_LIMIT
                        : ((req_size + 32'd3) & ~32'd3);

   // init arithmetic
   logic [31:0] base_rnd;
   logic        bad_arena;
   assign base_rnd  = (base_ff + 32'd3) & ~32'd3;
   assign bad_arena = (base_rnd == 32'd0) ||
                      (bytes_ff < bfha_pkg::ZONE_BYTES + bfha_pkg::HDR_BYTES);

   // merge decisions from the captured token
   logic prev_free, next_free, has_room;
   assign prev_free = tok_ff.pv && !tok_ff.pu;
   assign next_free = tok_ff.nv && !tok_ff.nu;
   assign has_room  = count_ff < CW'(N);

   assign key.is_alloc = (op_ff == bfha_pkg::OP_ALLOC);
   assign key.size     = size_ff;
   assign key.hdr      = hdr_ff;

   bfha_chain u_chain (
      .clock    (clock),
      .count    (count_ff),
      .key      (key),
      .cmd      (cmd),
      .tail_tok (tail_tok)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  bfha_pkg::OP_INIT:  state_in = bfha_pkg::S_INIT;
                  bfha_pkg::OP_ALLOC: state_in = bfha_pkg::S_SEARCH;
                  bfha_pkg::OP_FREE:  state_in = (req_ptr == 32'd0) ? bfha_pkg::S_FIN
                                                                  : bfha_pkg::S_SEARCH;
                  default:            state_in = bfha_pkg::S_FIN;
               endcase
            end
         end
         bfha_pkg::S_INIT: state_in = bfha_pkg::S_FIN;
         bfha_pkg::S_SEARCH: begin
            if (cnt_ff == IW'(N - 1)) state_in = bfha_pkg::S_CALC1;
         end
         bfha_pkg::S_CALC1: begin
            if (!tail_tok.found || (op_ff == bfha_pkg::OP_FREE && !tail_tok.used)) begin
               state_in = bfha_pkg::S_FIN;
            end else begin
               state_in = bfha_pkg::S_CALC2;
            end
         end
         bfha_pkg::S_CALC2: state_in = bfha_pkg::S_APPLY;
         bfha_pkg::S_APPLY: begin
            if (op_ff == bfha_pkg::OP_FREE && prev_free && next_free) begin
               state_in = bfha_pkg::S_APPLY2;
            end else begin
               state_in = bfha_pkg::S_FIN;
            end
         end
         bfha_pkg::S_APPLY2: state_in = bfha_pkg::S_FIN;
         bfha_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) state_in = bfha_pkg::S_IDLE;
         end
         default: state_in = bfha_pkg::S_IDLE;
      endcase
   end

   // outputs: table commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         bfha_pkg::S_INIT: begin
            cmd.wa.en       = !bad_arena;
            cmd.wa.idx      = '0;
            cmd.wa.start_en = 1'b1;
            cmd.wa.start    = base_rnd + bfha_pkg::ZONE_BYTES;
            cmd.wa.size_en  = 1'b1;
            cmd.wa.size     = bytes_ff - (bfha_pkg::ZONE_BYTES + bfha_pkg::HDR_BYTES);
            cmd.wa.used_en  = 1'b1;
            cmd.wa.used     = 1'b0;
         end
         bfha_pkg::S_APPLY: begin
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               // best entry always becomes used
               cmd.wa.en      = 1'b1;
               cmd.wa.idx     = tok_ff.idx;
               cmd.wa.used_en = 1'b1;
               cmd.wa.used    = 1'b1;
               cmd.wa.size    = size_ff;
               cmd.wb.idx     = tok_ff.idx + IW'(1);
               cmd.wb.start   = piece_ff;
               if (split_ff && next_free) begin
                  // remainder joins the following free segment
                  cmd.wa.size_en  = 1'b1;
                  cmd.wb.en       = 1'b1;
                  cmd.wb.start_en = 1'b1;
                  cmd.wb.size_en  = 1'b1;
                  cmd.wb.size     = nsum_ff;
               end else if (split_ff && has_room) begin
                  cmd.shr         = 1'b1;
                  cmd.sh_idx      = tok_ff.idx + IW'(1);
                  cmd.wa.size_en  = 1'b1;
                  cmd.wb.en       = 1'b1;
                  cmd.wb.start_en = 1'b1;
                  cmd.wb.size_en  = 1'b1;
                  cmd.wb.size     = restm_ff;
                  cmd.wb.used_en  = 1'b1;
                  cmd.wb.used     = 1'b0;
               end
            end else begin
               cmd.wa.en      = 1'b1;
               cmd.wa.size_en = 1'b1;
               cmd.wa.used_en = 1'b1;
               cmd.wa.used    = 1'b0;
               if (prev_free) begin
                  cmd.wa.idx  = tok_ff.idx - IW'(1);
                  cmd.wa.size = tok_ff.ps + m_ff;
                  cmd.shl     = 1'b1;
                  cmd.sh_idx  = tok_ff.idx;
               end else begin
                  // own size, plus the free follower and its header
                  cmd.wa.idx  = tok_ff.idx;
                  cmd.wa.size = tok_ff.size + b_ff;
                  cmd.shl     = next_free;
                  cmd.sh_idx  = tok_ff.idx + IW'(1);
               end
            end
         end
         bfha_pkg::S_APPLY2: begin
            cmd.shl    = 1'b1;
            cmd.sh_idx = tok_ff.idx;
         end
         default: cmd = '0;
      endcase
   end

   assign req_tready = (state_ff == bfha_pkg::S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfha_pkg::S_IDLE;
         count_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         bytes_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            if (csr_index == 1'b0) base_ff <= csr_wdata;
            else                   bytes_ff <= csr_wdata;
         end
         cnt_ff <= (state_ff == bfha_pkg::S_SEARCH) ? cnt_ff + IW'(1) : '0;
         case (state_ff)
            bfha_pkg::S_INIT: count_ff <= bad_arena ? CW'(0) : CW'(1);
            bfha_pkg::S_APPLY: begin
               if (op_ff == bfha_pkg::OP_ALLOC) begin
                  if (split_ff && !next_free && has_room) count_ff <= count_ff + CW'(1);
               end else if (prev_free || next_free) begin
                  count_ff <= count_ff - CW'(1);
               end
            end
            bfha_pkg::S_APPLY2: count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
         if (state_ff == bfha_pkg::S_FIN && state_in == bfha_pkg::S_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (accept) begin
               op_ff     <= req_op;
               size_ff   <= req_rounded;
               hdr_ff    <= req_ptr - bfha_pkg::HDR_BYTES;
               addr_ff   <= '0;
               status_ff <= bfha_pkg::ST_OK;
            end
         end
         bfha_pkg::S_INIT: begin
            status_ff <= bad_arena ? bfha_pkg::ST_NOFIT : bfha_pkg::ST_OK;
         end
         bfha_pkg::S_CALC1: begin
            tok_ff  <= tail_tok;
            rest_ff <= tail_tok.size - size_ff;
            a_ff    <= tail_tok.size + bfha_pkg::HDR_BYTES;
            b_ff    <= (tail_tok.nv && !tail_tok.nu) ? tail_tok.ns + bfha_pkg::HDR_BYTES
                                                     : 32'd0;
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               if (tail_tok.found) addr_ff <= tail_tok.start + bfha_pkg::HDR_BYTES;
               else                status_ff <= bfha_pkg::ST_NOFIT;
            end else if (!tail_tok.found || !tail_tok.used) begin
               status_ff <= bfha_pkg::ST_BADFREE;
            end
         end
         bfha_pkg::S_CALC2: begin
            piece_ff <= addr_ff + size_ff;
            nsum_ff  <= tok_ff.ns + rest_ff;
            restm_ff <= rest_ff - bfha_pkg::HDR_BYTES;
            split_ff <= rest_ff > bfha_pkg::HDR_BYTES;
            m_ff     <= a_ff + b_ff;
         end
         bfha_pkg::S_APPLY: begin
            if (op_ff == bfha_pkg::OP_ALLOC && split_ff && !next_free && !has_room) begin
               status_ff <= bfha_pkg::ST_NOSPLIT;
            end
         end
         bfha_pkg::S_FIN: begin
            if (state_in == bfha_pkg::S_IDLE) begin
               rsp_addr_ff   <= addr_ff;
               rsp_status_ff <= status_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_addr_ff};

   // table never holds more entries than cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("segment count beyond table size");

   // count only moves in init and table update steps, or on reset
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == bfha_pkg::S_INIT || $past(state_ff) == bfha_pkg::S_APPLY ||
          $past(state_ff) == bfha_pkg::S_APPLY2 || $past(reset)))
      else $error("segment count changed outside an update");

   // a pending response is never overwritten before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == bfha_pkg::S_FIN) |=>
         (state_ff == bfha_pkg::S_FIN))
      else $error("result left fin while response pending");

endmodule
